/* hw/rtl/occupancy_grid_area_engine_defines.svh */
// Assertion macros used by the occupancy grid area engine checker.
`ifndef OCCUPANCY_GRID_AREA_ENGINE_DEFINES_SVH
`define OCCUPANCY_GRID_AREA_ENGINE_DEFINES_SVH

// Condition in the same cycle implies the consequence in that cycle.
`define OGAE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in one cycle implies the consequence in the next cycle.
`define OGAE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ogae_pkg.sv */
// Shared constants, types and command/status structs of the occupancy grid area engine.
package ogae_pkg;

    localparam int MAX_GRID = 64;
    localparam int ADDR_W   = $clog2(MAX_GRID);
    localparam int CNT_W    = ADDR_W + 1;

    localparam int GRID_W  = 7;
    localparam int COORD_W = 8;
    localparam int SIZE_W  = 7;
    localparam int EXT_W   = 10;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    localparam logic signed [EXT_W-1:0] GRID_MAX_E = EXT_W'(MAX_GRID);
    localparam logic signed [EXT_W-1:0] ZERO_E     = '0;
    localparam logic signed [EXT_W-1:0] ONE_E      = EXT_W'(1);
    localparam logic signed [EXT_W-1:0] TWO_E      = EXT_W'(2);

    typedef enum logic [1:0] {
        MODE_MARK       = 2'd0,
        MODE_CHECK_AREA = 2'd1,
        MODE_DEPLOY     = 2'd2,
        MODE_QUERY      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic prep;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

/* hw/rtl/ogae_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module ogae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/ogae_ctrl.sv */
// Sequencing state machine of the occupancy grid area engine.
module ogae_ctrl
    import ogae_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = status.skip ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/ogae_datapath.sv */
// Bounds arithmetic, row scan over the occupancy memory and the result register.
module ogae_datapath
    import ogae_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [1:0]        s_tuser,
    input  logic [31:0]       s_tdata,
    input  logic              cfg_valid,
    input  logic [GRID_W-1:0] cfg_data,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [7:0]        m_tdata
);

    function automatic logic [CNT_W-1:0] clip(input logic signed [EXT_W-1:0] v,
                                             input logic signed [EXT_W-1:0] n);
        logic signed [EXT_W-1:0] r;
        r = v;
        if (v < ZERO_E)
        begin
            r = ZERO_E;
        end
        else if (v > n)
        begin
            r = n;
        end
        return r[CNT_W-1:0];
    endfunction

    // Request fields
    mode_t                     mode_reg;
    logic signed [COORD_W-1:0] sx_reg;
    logic signed [COORD_W-1:0] sy_reg;
    logic [SIZE_W-1:0]         w_reg;
    logic [SIZE_W-1:0]         h_reg;
    logic                      occ_reg;

    logic [GRID_W-1:0]         grid_reg;

    // Clipped bounds and scan state
    logic [CNT_W-1:0]    xlo_reg;
    logic [CNT_W-1:0]    xhi_reg;
    logic [CNT_W-1:0]    ylo_reg;
    logic [CNT_W-1:0]    yhi_reg;
    logic                skip_reg;
    logic                preset_reg;
    logic [MAX_GRID-1:0] mask_reg;
    logic [CNT_W-1:0]    row_reg;
    logic                pend_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic                rvalid_reg;
    logic                hit_reg;
    logic [MAX_GRID-1:0] valid_reg;
    logic                out_valid_reg;
    logic                answer_reg;

    logic signed [EXT_W-1:0] n_e;
    logic signed [EXT_W-1:0] grid_e;
    logic signed [EXT_W-1:0] sx_e;
    logic signed [EXT_W-1:0] sy_e;
    logic signed [EXT_W-1:0] w_e;
    logic signed [EXT_W-1:0] h_e;
    logic signed [EXT_W-1:0] xlo_s;
    logic signed [EXT_W-1:0] xhi_s;
    logic signed [EXT_W-1:0] ylo_s;
    logic signed [EXT_W-1:0] yhi_s;
    logic                    cell_in;
    logic                    rect_in;
    logic                    skip_c;
    logic                    preset_c;

    logic                    issue;
    logic [ADDR_W-1:0]       rd_addr;
    logic [MAX_GRID-1:0]     ram_q;
    logic [MAX_GRID-1:0]     row_data;
    logic                    we;
    logic [MAX_GRID-1:0]     wdata;
    logic                    answer_c;

    assign grid_e = $signed({{(EXT_W-GRID_W){1'b0}}, grid_reg});
    assign n_e    = (grid_e > GRID_MAX_E) ? GRID_MAX_E : grid_e;
    assign sx_e   = $signed({{(EXT_W-COORD_W){sx_reg[COORD_W-1]}}, sx_reg});
    assign sy_e   = $signed({{(EXT_W-COORD_W){sy_reg[COORD_W-1]}}, sy_reg});
    assign w_e    = $signed({{(EXT_W-SIZE_W){1'b0}}, w_reg});
    assign h_e    = $signed({{(EXT_W-SIZE_W){1'b0}}, h_reg});

    assign cell_in = (sx_e >= ZERO_E) && (sy_e >= ZERO_E) && (sx_e < n_e) && (sy_e < n_e);

    // Every mode becomes a window [lo, hi) in each axis, clipped to the grid.
    always_comb
    begin
        xlo_s    = sx_e;
        xhi_s    = sx_e + w_e;
        ylo_s    = sy_e;
        yhi_s    = sy_e + h_e;
        skip_c   = 1'b0;
        preset_c = 1'b0;
        case (mode_reg)
            MODE_MARK:
            begin
                skip_c = 1'b0;
            end
            MODE_CHECK_AREA:
            begin
                skip_c = !rect_in;
            end
            MODE_DEPLOY:
            begin
                xlo_s  = sx_e - ONE_E;
                xhi_s  = sx_e + TWO_E;
                ylo_s  = sy_e - ONE_E;
                yhi_s  = sy_e + TWO_E;
                skip_c = !cell_in;
            end
            MODE_QUERY:
            begin
                xhi_s    = sx_e + ONE_E;
                yhi_s    = sy_e + ONE_E;
                skip_c   = !cell_in;
                preset_c = 1'b1;
            end
            default:
            begin
                skip_c = 1'b1;
            end
        endcase
    end

    assign rect_in = (sx_e >= ZERO_E) && (sy_e >= ZERO_E)
                     && (sx_e + w_e <= n_e) && (sy_e + h_e <= n_e);

    // Row scan: a read is issued each cycle while the row that came back last
    // cycle is checked or rewritten.
    assign issue    = cmd.scan && (row_reg < yhi_reg);
    assign rd_addr  = row_reg[ADDR_W-1:0];
    assign row_data = rvalid_reg ? ram_q : '0;
    assign we       = pend_reg && (mode_reg == MODE_MARK);
    assign wdata    = (row_data & ~mask_reg) | (occ_reg ? mask_reg : '0);

    ogae_ram #(
        .WIDTH (MAX_GRID),
        .DEPTH (MAX_GRID)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (pend_addr_reg),
        .wdata (wdata),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_comb
    begin
        if (mode_reg == MODE_MARK)
        begin
            answer_c = 1'b1;
        end
        else if (skip_reg)
        begin
            answer_c = preset_reg;
        end
        else if (mode_reg == MODE_QUERY)
        begin
            answer_c = hit_reg;
        end
        else
        begin
            answer_c = !hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg      <= GRID_RESET;
            valid_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                grid_reg <= cfg_data;
            end
            if (we)
            begin
                valid_reg[pend_addr_reg] <= 1'b1;
            end
            pend_reg <= issue;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_t'(s_tuser);
            sx_reg   <= s_tdata[7:0];
            sy_reg   <= s_tdata[15:8];
            w_reg    <= s_tdata[22:16];
            h_reg    <= s_tdata[29:23];
            occ_reg  <= s_tdata[30];
        end
        if (cmd.setup)
        begin
            xlo_reg    <= clip(xlo_s, n_e);
            xhi_reg    <= clip(xhi_s, n_e);
            ylo_reg    <= clip(ylo_s, n_e);
            yhi_reg    <= clip(yhi_s, n_e);
            skip_reg   <= skip_c;
            preset_reg <= preset_c;
        end
        if (cmd.prep)
        begin
            mask_reg <= ~({MAX_GRID{1'b1}} << xhi_reg) & ({MAX_GRID{1'b1}} << xlo_reg);
            row_reg  <= ylo_reg;
            hit_reg  <= 1'b0;
        end
        if (issue)
        begin
            row_reg       <= row_reg + CNT_W'(1);
            pend_addr_reg <= rd_addr;
            rvalid_reg    <= valid_reg[rd_addr];
        end
        if (pend_reg && (mode_reg != MODE_MARK))
        begin
            hit_reg <= hit_reg | (|(row_data & mask_reg));
        end
        if (cmd.finish)
        begin
            answer_reg <= answer_c;
        end
    end

    assign status.skip      = skip_reg;
    assign status.scan_done = !(row_reg < yhi_reg) && !pend_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, answer_reg};

endmodule

/* hw/rtl/occupancy_grid_area_engine.sv */
// Top level of the occupancy grid area engine: controller and datapath.
//
//  channel | direction | handshake              | payload
//  s       | in        | s_tvalid / s_tready    | s_tdata, s_tuser (mode)
//  m       | out       | m_tvalid / m_tready    | m_tdata (answer)
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_data (grid_size)
//
// A request goes from transfer through setup and bounds preparation and a scan of the R
// grid rows its window covers (1 to 64) to the result register; a window with no rows
// reads none, and a request rejected by the bounds test skips the scan. The row scan reads
// one memory row per cycle, with a mark written back through the second port in the cycle after its read.
// Reset clears the grid size to 64 and every row's valid bit, so all cells read free.
// A result waits in the output register while the next request is transferred; that
// request then holds before its result until the output register is free.
module occupancy_grid_area_engine
    import ogae_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [7:0] start_x, [15:8] start_y, [22:16] area_width, [29:23] area_height,
    // [30] occupied, [31] zero
    input  logic [31:0]       s_tdata,
    // [1:0] mode
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] answer, [7:1] zero
    output logic [7:0]        m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GRID_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    ogae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ogae_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

/* hw/rtl/ogae_checker.sv */
// Port-level checker of the occupancy grid area engine, bound to the top level.
`include "occupancy_grid_area_engine_defines.svh"

module ogae_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    `OGAE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `OGAE_ASSERT_SAME(a_out_pad, m_tvalid, m_tdata[7:1] == 7'd0, "result padding bits not zero")
    `OGAE_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `OGAE_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready, !$rose(m_tvalid), "result appeared too early")
    `OGAE_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "configuration write not taken")

endmodule

bind occupancy_grid_area_engine ogae_checker u_ogae_checker (.*);
